// ===== rtl/core/bbd_pkg.sv =====
// Shared types and constants for the byte-to-display-digits block.
// Used by bbd_cell, bbd_fmt and byte_to_display_digits_top.
package bbd_pkg;

    localparam int VAL_W   = 8;               // input byte width
    localparam int BCD_W   = 12;              // three BCD nibbles
    localparam int DIG_W   = 5;               // display digit code width
    localparam int N_CELLS = VAL_W;           // one shift cell per input bit

    // display_mode register codes; the unused code acts as hexadecimal
    localparam logic [1:0] MODE_UNS = 2'd0;
    localparam logic [1:0] MODE_SGN = 2'd1;
    localparam logic [1:0] MODE_HEX = 2'd2;

    localparam logic [DIG_W-1:0] DIG_BLANK = 5'd0;
    localparam logic [DIG_W-1:0] DIG_MINUS = 5'd16;

    // One request as it travels down the conversion row
    typedef struct packed {
        logic             valid;
        logic [1:0]       mode;
        logic             neg;
        logic [VAL_W-1:0] raw;
        logic [VAL_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } t_stage;

endpackage

// ===== rtl/core/bbd_cell.sv =====
// One shift-and-add-3 cell of the binary to BCD row.
// Depends on bbd_pkg for the stage record.
module bbd_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bbd_pkg::t_stage i_stage,
    output bbd_pkg::t_stage o_stage
);

    bbd_pkg::t_stage               r_stage;
    bbd_pkg::t_stage               n_stage;
    logic [bbd_pkg::BCD_W-1:0]     adj;

    // correct every BCD nibble that would overflow on the shift
    always_comb begin
        for (int k = 0; k < bbd_pkg::BCD_W / 4; k++) begin
            if (i_stage.bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = i_stage.bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = i_stage.bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_stage      = i_stage;
        n_stage.bcd  = {adj[bbd_pkg::BCD_W-2:0], i_stage.bin[bbd_pkg::VAL_W-1]};
        n_stage.bin  = {i_stage.bin[bbd_pkg::VAL_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.mode <= n_stage.mode;
        r_stage.neg  <= n_stage.neg;
        r_stage.raw  <= n_stage.raw;
        r_stage.bin  <= n_stage.bin;
        r_stage.bcd  <= n_stage.bcd;
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/core/bbd_fmt.sv =====
// Output stage: blanks leading zeros, places the minus sign, picks hex nibbles.
// Depends on bbd_pkg for the stage record and digit codes.
module bbd_fmt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbd_pkg::t_stage             i_stage,
    output logic                        o_valid,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_0,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_1,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_2,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_3,
    output logic                        o_show_0,
    output logic                        o_show_1,
    output logic                        o_show_2,
    output logic                        o_show_3
);

    logic                        r_valid;
    logic [bbd_pkg::DIG_W-1:0]   r_dig [4];
    logic [3:0]                  r_show;
    logic [bbd_pkg::DIG_W-1:0]   n_dig [4];
    logic [3:0]                  n_show;
    logic [3:0]                  nib0, nib1, nib2;
    logic                        use_hex;

    assign nib0    = i_stage.bcd[3:0];
    assign nib1    = i_stage.bcd[7:4];
    assign nib2    = i_stage.bcd[11:8];
    assign use_hex = (i_stage.mode != bbd_pkg::MODE_UNS)
                  && (i_stage.mode != bbd_pkg::MODE_SGN);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_dig[k] = bbd_pkg::DIG_BLANK;
        end
        n_show = 4'b0000;
        if (use_hex) begin
            n_dig[0] = {1'b0, i_stage.raw[3:0]};
            n_dig[1] = {1'b0, i_stage.raw[7:4]};
            n_show   = 4'b0011;
        end else begin
            n_dig[0] = {1'b0, nib0};
            n_show[0] = 1'b1;
            if (nib2 != 4'd0) begin
                n_dig[1] = {1'b0, nib1};
                n_dig[2] = {1'b0, nib2};
                n_show[2:1] = 2'b11;
                if (i_stage.neg) begin
                    n_dig[3]  = bbd_pkg::DIG_MINUS;
                    n_show[3] = 1'b1;
                end
            end else if (nib1 != 4'd0) begin
                n_dig[1]  = {1'b0, nib1};
                n_show[1] = 1'b1;
                if (i_stage.neg) begin
                    n_dig[2]  = bbd_pkg::DIG_MINUS;
                    n_show[2] = 1'b1;
                end
            end else if (i_stage.neg) begin
                n_dig[1]  = bbd_pkg::DIG_MINUS;
                n_show[1] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_show <= n_show;
    end

    assign o_valid   = r_valid;
    assign o_digit_0 = r_dig[0];
    assign o_digit_1 = r_dig[1];
    assign o_digit_2 = r_dig[2];
    assign o_digit_3 = r_dig[3];
    assign o_show_0  = r_show[0];
    assign o_show_1  = r_show[1];
    assign o_show_2  = r_show[2];
    assign o_show_3  = r_show[3];

endmodule

// ===== rtl/core/byte_to_display_digits_top.sv =====
// Top level: byte to four display digit codes plus show mask.
// Depends on bbd_pkg, bbd_cell (shift-and-add-3 row) and bbd_fmt.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  request  | start / busy           | i_value[7:0]
//  result   | o_valid (strobe)       | o_digit_0..3[4:0], o_show_0..3
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_data[1:0] (display_mode)
//
// One request per cycle; each result passes through one entry register,
// eight shift-and-add-3 cells and one output register.
// busy stays low. The mode travels with each request down the row.
// Synchronous active-low reset clears display_mode to 0 and all valid bits.
// Results come as one-cycle strobes; the receiver cannot stall them.
module byte_to_display_digits_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bbd_pkg::VAL_W-1:0]   i_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_data,
    output logic                        o_valid,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_0,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_1,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_2,
    output logic [bbd_pkg::DIG_W-1:0]   o_digit_3,
    output logic                        o_show_0,
    output logic                        o_show_1,
    output logic                        o_show_2,
    output logic                        o_show_3
);

    logic [1:0]                 r_mode;
    bbd_pkg::t_stage            r_entry;
    bbd_pkg::t_stage            n_entry;
    bbd_pkg::t_stage            chain [bbd_pkg::N_CELLS+1];
    logic                       neg;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bbd_pkg::MODE_UNS;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // two's complement magnitude; -128 maps to 0x80 which reads as 128
    assign neg = (r_mode == bbd_pkg::MODE_SGN) && i_value[bbd_pkg::VAL_W-1];

    always_comb begin
        n_entry.valid = start;
        n_entry.mode  = r_mode;
        n_entry.neg   = neg;
        n_entry.raw   = i_value;
        n_entry.bin   = neg ? (~i_value + 8'd1) : i_value;
        n_entry.bcd   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.mode <= n_entry.mode;
        r_entry.neg  <= n_entry.neg;
        r_entry.raw  <= n_entry.raw;
        r_entry.bin  <= n_entry.bin;
        r_entry.bcd  <= n_entry.bcd;
    end

    assign chain[0] = r_entry;

    for (genvar g = 0; g < bbd_pkg::N_CELLS; g++) begin : g_cell
        bbd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    bbd_fmt u_fmt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (chain[bbd_pkg::N_CELLS]),
        .o_valid   (o_valid),
        .o_digit_0 (o_digit_0),
        .o_digit_1 (o_digit_1),
        .o_digit_2 (o_digit_2),
        .o_digit_3 (o_digit_3),
        .o_show_0  (o_show_0),
        .o_show_1  (o_show_1),
        .o_show_2  (o_show_2),
        .o_show_3  (o_show_3)
    );

endmodule
